// ===== sv/ffra_pkg.sv =====
package ffra_pkg;

	// Field widths
	localparam int REQ_W      = 31;
	localparam int ACTIVE_W   = 11;
	localparam int CAP_W      = 31;
	localparam int ROWNUM_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// Default row count (tree leaves)
	localparam int DEF_MAX_ROWS = 1024;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd1;

	// Register reset values
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;
	localparam logic [CAP_W-1:0]    WIDTH_RESET  = 31'd1024;

	typedef enum logic [2:0] {
		ST_REFILL,
		ST_IDLE,
		ST_DESCEND,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_req;
		logic descend;
		logic update;
		logic refill;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cfg_write;
		logic lvl_last;
		logic lvl_zero;
		logic hit;
		logic sweep_done;
	} dp_sts_t;

endpackage

// ===== sv/ffra_ram.sv =====
module ffra_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/ffra_ctrl.sv =====
module ffra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ffra_pkg::dp_sts_t sts,
	output ffra_pkg::dp_cmd_t cmd
);

	ffra_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffra_pkg::ST_REFILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ffra_pkg::ST_REFILL: begin
				cmd.refill = 1'b1;
				if (sts.sweep_done) begin
					state_d = ffra_pkg::ST_IDLE;
				end
			end
			ffra_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ffra_pkg::ST_DESCEND;
				end
			end
			ffra_pkg::ST_DESCEND: begin
				cmd.descend = 1'b1;
				if (sts.lvl_last) begin
					state_d = sts.hit ? ffra_pkg::ST_UPDATE : ffra_pkg::ST_FINISH;
				end
			end
			ffra_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				if (sts.lvl_zero) begin
					state_d = ffra_pkg::ST_FINISH;
				end
			end
			ffra_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ffra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffra_pkg::ST_REFILL;
			end
		endcase
		// any register write restarts the refill sweep
		if (sts.cfg_write) begin
			state_d = ffra_pkg::ST_REFILL;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ffra_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== sv/ffra_datapath.sv =====
module ffra_datapath #(
	parameter int MAX_ROWS = ffra_pkg::DEF_MAX_ROWS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [ffra_pkg::REQ_W-1:0]          request_size,
	input  logic                                cfg_valid,
	input  logic [ffra_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ffra_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  ffra_pkg::dp_cmd_t                   cmd,
	output ffra_pkg::dp_sts_t                   sts,
	output logic                                found,
	output logic [ffra_pkg::ROWNUM_W-1:0]       row_number
);

	localparam int LEVELS   = $clog2(MAX_ROWS);
	localparam int PAIRS    = 1 << LEVELS;
	localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int W        = ffra_pkg::CAP_W;
	localparam int ROWSUM_W = (LEVELS + 1 > ffra_pkg::ROWNUM_W) ? LEVELS + 1
		: ffra_pkg::ROWNUM_W;

	// Configuration registers
	logic [ffra_pkg::ACTIVE_W-1:0] active_rows_q;
	logic [W-1:0]                  row_width_q;

	// Walk state
	logic [LEVELS-1:0] sweep_q;
	logic [LEVELS-1:0] node_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [LEVELS:0]   leaf_q;
	logic [W-1:0]      val_q;
	logic [W-1:0]      req_q;
	logic [W-1:0]      sib_q [LEVELS];
	logic              res_found_q;
	logic [ffra_pkg::ROWNUM_W-1:0] res_row_q;
	logic              found_q;
	logic [ffra_pkg::ROWNUM_W-1:0] row_number_q;

	// RAM: entry k holds the child pair {node 2k, node 2k+1}
	logic              ram_we;
	logic [LEVELS-1:0] ram_waddr;
	logic [2*W-1:0]    ram_wdata;
	logic [LEVELS-1:0] ram_raddr;
	logic [2*W-1:0]    ram_rdata;

	logic [W-1:0]        left_val, right_val, chosen, sib_new, sib_cur, up_max, diff;
	logic                go_right, fits, cfg_write;
	logic [LEVELS:0]     child;
	logic [LEVELS-1:0]   row;
	logic [ROWSUM_W-1:0] row_plus;
	logic                hit;

	ffra_ram #(
		.WIDTH (2 * W),
		.DEPTH (PAIRS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Descent step: go left when the left subtree can hold the request
	assign left_val  = ram_rdata[2*W-1:W];
	assign right_val = ram_rdata[W-1:0];
	assign go_right  = (left_val < req_q);
	assign chosen    = go_right ? right_val : left_val;
	assign sib_new   = go_right ? left_val : right_val;
	assign child     = {node_q, go_right};
	assign row       = child[LEVELS-1:0];
	assign fits      = (chosen >= req_q);
	assign diff      = chosen - req_q;
	assign row_plus  = ROWSUM_W'(row) + ROWSUM_W'(1);
	assign hit       = fits && (32'(row) < 32'(MAX_ROWS))
		&& (32'(row) < 32'(active_rows_q));

	// Update step: parent max from the new value and the saved sibling
	assign sib_cur = sib_q[lvl_q];
	assign up_max  = (val_q > sib_cur) ? val_q : sib_cur;

	assign cfg_write = cfg_valid
		&& ((cfg_index == ffra_pkg::CFG_ACTIVE_ROWS) || (cfg_index == ffra_pkg::CFG_ROW_WIDTH));

	// RAM port muxing
	always_comb begin
		ram_we    = cmd.refill | cmd.update;
		ram_waddr = cmd.update ? leaf_q[LEVELS:1] : sweep_q;
		if (cmd.update) begin
			ram_wdata = leaf_q[0] ? {sib_cur, val_q} : {val_q, sib_cur};
		end else begin
			ram_wdata = {row_width_q, row_width_q};
		end
		ram_raddr = cmd.descend ? child[LEVELS-1:0] : LEVELS'(1);
	end

	// Configuration and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q <= ffra_pkg::ACTIVE_RESET;
			row_width_q   <= ffra_pkg::WIDTH_RESET;
			sweep_q       <= '0;
			node_q        <= LEVELS'(1);
			lvl_q         <= '0;
		end else begin
			if (cfg_valid && cfg_index == ffra_pkg::CFG_ACTIVE_ROWS) begin
				active_rows_q <= cfg_data[ffra_pkg::ACTIVE_W-1:0];
			end
			if (cfg_valid && cfg_index == ffra_pkg::CFG_ROW_WIDTH) begin
				row_width_q <= cfg_data[W-1:0];
			end
			if (cfg_write) begin
				sweep_q <= '0;
			end else if (cmd.refill) begin
				sweep_q <= sweep_q + LEVELS'(1);
			end
			if (cmd.load_req) begin
				node_q <= LEVELS'(1);
				lvl_q  <= '0;
			end else if (cmd.descend && !sts.lvl_last) begin
				node_q <= child[LEVELS-1:0];
				lvl_q  <= lvl_q + LVL_W'(1);
			end else if (cmd.update && !sts.lvl_zero) begin
				lvl_q <= lvl_q - LVL_W'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= request_size;
		end
		if (cmd.descend) begin
			sib_q[lvl_q] <= sib_new;
			if (sts.lvl_last) begin
				leaf_q      <= child;
				val_q       <= diff;
				res_found_q <= hit;
				res_row_q   <= hit ? row_plus[ffra_pkg::ROWNUM_W-1:0] : '0;
			end
		end
		if (cmd.update) begin
			leaf_q <= leaf_q >> 1;
			val_q  <= up_max;
		end
		if (cmd.load_out) begin
			found_q      <= res_found_q;
			row_number_q <= res_row_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.cfg_write  = cfg_write;
		sts.lvl_last   = (lvl_q == LVL_W'(LEVELS - 1));
		sts.lvl_zero   = (lvl_q == '0);
		sts.hit        = hit;
		sts.sweep_done = (sweep_q == LEVELS'(PAIRS - 1));
	end

	assign found      = found_q;
	assign row_number = row_number_q;

endmodule

// ===== sv/first_fit_row_allocator_unit.sv =====
// First-fit row allocator.
// Keeps a remaining capacity per row and a max tree over the rows. A request
// transfer on the input channel (in_valid/in_ready, request_size) is placed in
// the lowest-numbered active row with enough capacity; that row is charged and
// its one-based number comes back on the output channel (out_valid/out_ready,
// found, row_number). With no fitting row, found is 0, row_number is 0 and
// nothing changes.
// Timing: one item at a time. A fitting request does one RAM read per tree
// level going down, one RAM write per level going back up, and then a load of
// the output register. A request that does not fit does the reads and the
// load but no writes.
// Reset and configuration: after reset, and after each write to register 0
// (active_rows) or 1 (row_width), a sweep writes row_width into every tree
// entry, with in_ready low. The configuration port always takes a transfer;
// write it only while idle.
// Stall: a finished result sits in the output register while the next request
// is accepted and worked; the block waits before its own result only if that
// register is still full.
module first_fit_row_allocator_unit #(
	parameter int MAX_ROWS = ffra_pkg::DEF_MAX_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ffra_pkg::REQ_W-1:0]      request_size,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [ffra_pkg::ROWNUM_W-1:0]   row_number,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffra_pkg::CFG_DATA_W-1:0] cfg_data
);

	ffra_pkg::dp_cmd_t cmd;
	ffra_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffra_datapath #(
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_size (request_size),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.found        (found),
		.row_number   (row_number)
	);

endmodule

// ===== sv/ffra_checker.sv =====
module ffra_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [ffra_pkg::REQ_W-1:0]      request_size,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            found,
	input logic [ffra_pkg::ROWNUM_W-1:0]   row_number,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [ffra_pkg::CFG_DATA_W-1:0] cfg_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(row_number))
		else $error("result changed while stalled");

	// A miss reports row zero
	a_miss_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> row_number == '0)
		else $error("miss with nonzero row");

	// A hit reports a one-based row
	a_hit_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> row_number != '0)
		else $error("hit with row zero");

	// One request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// A register write starts the refill sweep
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready
		&& (cfg_index == ffra_pkg::CFG_ACTIVE_ROWS || cfg_index == ffra_pkg::CFG_ROW_WIDTH)
		|=> !in_ready)
		else $error("request taken during refill");

endmodule

bind first_fit_row_allocator_unit ffra_checker u_ffra_checker (.*);
